// ===== design/dfm_pkg.sv =====
// Shared types and constants for the sync/length/checksum frame deframer.
// Used by the result channel interface, the controller, the datapath and the top level.
// No dependencies.
package dfm_pkg;

  // Longest allowed frame: sync, command, length, payload and checksum.
  localparam int MAX_FRAME_BYTES = 64;
  localparam int HDR_BYTES       = 3;
  // Longest payload that still fits in a frame.
  localparam int PAY_MAX         = MAX_FRAME_BYTES - HDR_BYTES - 1;
  // Width of the length and index counters, and of the store address.
  localparam int LEN_W           = $clog2(PAY_MAX + 1);
  localparam int MEM_AW          = (PAY_MAX > 1) ? $clog2(PAY_MAX) : 1;

  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] CMD_LOW    = 8'h01;
  localparam logic [7:0] CMD_HIGH   = 8'h06;
  localparam logic [7:0] SYNC_RESET = 8'hA5;

  // Field widths of the result word.
  localparam int EVENT_W = 3;
  localparam int COUNT_W = 6;

  typedef enum logic [EVENT_W-1:0] {
    EV_DATA     = 3'd0,
    EV_BAD_SYNC = 3'd1,
    EV_BAD_CMD  = 3'd2,
    EV_BAD_LEN  = 3'd3,
    EV_BAD_SUM  = 3'd4
  } dfm_event_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       open_frame;  // load running sum with sync, start a frame
    logic       add_byte;    // add the incoming byte to the running sum
    logic       store_cmd;   // capture the command byte
    logic       store_len;   // capture the length byte, clear the fill index
    logic       store_pay;   // write a payload byte, advance the fill index
    logic       load_err;    // load an error result into the output register
    dfm_event_t err_code;
    logic       load_empty;  // load the empty-frame result
    logic       clr_rd;      // restart the payload read index
    logic       inc_rd;      // advance the payload read index
    logic       load_data;   // read the store and load a data result
  } dfm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sync;      // incoming byte equals the sync value
    logic is_idle;      // incoming byte is the idle byte
    logic cmd_ok;       // incoming byte is a valid command
    logic len_bad;      // incoming length makes the frame too long
    logic len_zero;     // incoming length is zero
    logic pay_done;     // the incoming payload byte is the frame's last
    logic sum_ok;       // incoming byte matches the running sum
    logic frame_empty;  // stored frame length is zero
    logic out_last;     // the held result ends its run
  } dfm_stat_t;

endpackage

// ===== design/dfm_in_if.sv =====
// Input channel: one received byte per word, valid/ready handshake.
// Depends on nothing but the port width of the byte.
interface dfm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/dfm_out_if.sv =====
// Result channel: one frame data or event word per handshake.
// Depends on dfm_pkg for the field widths.
interface dfm_out_if;
  logic                        valid;
  logic                        ready;
  logic [dfm_pkg::EVENT_W-1:0] event_res;
  logic [7:0]                  command_code;
  logic [dfm_pkg::COUNT_W-1:0] payload_count;
  logic [7:0]                  payload_value;
  logic [dfm_pkg::COUNT_W-1:0] byte_position;
  logic                        last_of_run;

  modport source (
    output valid, output event_res, output command_code, output payload_count,
    output payload_value, output byte_position, output last_of_run, input ready
  );
  modport sink (
    input valid, input event_res, input command_code, input payload_count,
    input payload_value, input byte_position, input last_of_run, output ready
  );
endinterface

// ===== design/dfm_dp.sv =====
// Deframer datapath: sync register, running sum, frame fields, payload store
// and the result register. Depends on dfm_pkg; driven by dfm_ctrl.
module dfm_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,
  input  logic [7:0]                  rx_byte,
  input  dfm_pkg::dfm_cmd_t           cmd,
  output dfm_pkg::dfm_stat_t          stat,
  output logic [dfm_pkg::EVENT_W-1:0] event_res,
  output logic [7:0]                  command_code,
  output logic [dfm_pkg::COUNT_W-1:0] payload_count,
  output logic [7:0]                  payload_value,
  output logic [dfm_pkg::COUNT_W-1:0] byte_position,
  output logic                        last_of_run
);

  localparam int EXT_W = dfm_pkg::LEN_W + dfm_pkg::COUNT_W;

  logic [7:0]                sync_r;
  logic [7:0]                sum_r, sum_nxt;
  logic [7:0]                cmd_r;
  logic [dfm_pkg::LEN_W-1:0] len_r;
  logic [dfm_pkg::LEN_W-1:0] wr_idx_r;
  logic [dfm_pkg::LEN_W-1:0] rd_idx_r;

  logic [7:0] mem [dfm_pkg::PAY_MAX];
  logic [7:0] rd_q_r;

  logic [dfm_pkg::EVENT_W-1:0] out_event_r;
  logic [7:0]                  out_cmd_r;
  logic [dfm_pkg::COUNT_W-1:0] out_count_r;
  logic [dfm_pkg::COUNT_W-1:0] out_pos_r;
  logic                        out_last_r;
  logic                        out_mem_r;

  logic [dfm_pkg::LEN_W:0] wr_next;
  logic [dfm_pkg::LEN_W:0] rd_next;
  logic [EXT_W-1:0]        len_ext;
  logic [EXT_W-1:0]        pos_ext;

  assign wr_next = {1'b0, wr_idx_r} + 1'b1;
  assign rd_next = {1'b0, rd_idx_r} + 1'b1;
  assign len_ext = EXT_W'(len_r);
  assign pos_ext = EXT_W'(rd_idx_r);
  assign sum_nxt = sum_r + rx_byte;

  // Status on the incoming byte and the stored frame.
  always_comb begin
    stat.is_sync     = (rx_byte == sync_r);
    stat.is_idle     = (rx_byte == dfm_pkg::IDLE_BYTE);
    stat.cmd_ok      = (rx_byte >= dfm_pkg::CMD_LOW) && (rx_byte <= dfm_pkg::CMD_HIGH);
    stat.len_bad     = ({1'b0, rx_byte} > 9'(dfm_pkg::PAY_MAX));
    stat.len_zero    = (rx_byte == 8'd0);
    stat.pay_done    = (wr_next == {1'b0, len_r});
    stat.sum_ok      = (rx_byte == sum_r);
    stat.frame_empty = (len_r == '0);
    stat.out_last    = out_last_r;
  end

  // Sync register, running sum, frame fields and the two store indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= dfm_pkg::SYNC_RESET;
      sum_r    <= '0;
      cmd_r    <= '0;
      len_r    <= '0;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
      if (cmd.open_frame) begin
        sum_r <= sync_r;
        len_r <= '0;
      end else if (cmd.add_byte) begin
        sum_r <= sum_nxt;
      end
      if (cmd.store_cmd) begin
        cmd_r <= rx_byte;
      end
      if (cmd.store_len) begin
        len_r    <= rx_byte[dfm_pkg::LEN_W-1:0];
        wr_idx_r <= '0;
      end else if (cmd.store_pay) begin
        wr_idx_r <= wr_next[dfm_pkg::LEN_W-1:0];
      end
      if (cmd.clr_rd) begin
        rd_idx_r <= '0;
      end else if (cmd.inc_rd) begin
        rd_idx_r <= rd_next[dfm_pkg::LEN_W-1:0];
      end
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_pay) begin
      mem[wr_idx_r[dfm_pkg::MEM_AW-1:0]] <= rx_byte;
    end
    if (cmd.load_data) begin
      rd_q_r <= mem[rd_idx_r[dfm_pkg::MEM_AW-1:0]];
    end
  end

  // Result register, loaded for an error, an empty frame or a data word.
  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_event_r <= cmd.err_code;
      out_cmd_r   <= '0;
      out_count_r <= '0;
      out_pos_r   <= '0;
      out_last_r  <= 1'b1;
      out_mem_r   <= 1'b0;
    end else if (cmd.load_empty) begin
      out_event_r <= dfm_pkg::EV_DATA;
      out_cmd_r   <= cmd_r;
      out_count_r <= '0;
      out_pos_r   <= '0;
      out_last_r  <= 1'b1;
      out_mem_r   <= 1'b0;
    end else if (cmd.load_data) begin
      out_event_r <= dfm_pkg::EV_DATA;
      out_cmd_r   <= cmd_r;
      out_count_r <= len_ext[dfm_pkg::COUNT_W-1:0];
      out_pos_r   <= pos_ext[dfm_pkg::COUNT_W-1:0];
      out_last_r  <= (rd_next == {1'b0, len_r});
      out_mem_r   <= 1'b1;
    end
  end

  assign event_res     = out_event_r;
  assign command_code  = out_cmd_r;
  assign payload_count = out_count_r;
  assign payload_value = out_mem_r ? rd_q_r : 8'd0;
  assign byte_position = out_pos_r;
  assign last_of_run   = out_last_r;

endmodule

// ===== design/dfm_ctrl.sv =====
// Deframer controller: parse-phase state machine and result sequencing.
// Depends on dfm_pkg; drives dfm_dp through command and status structs.
module dfm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dfm_pkg::dfm_stat_t  stat,
  output dfm_pkg::dfm_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_SYNC,
    ST_CMD,
    ST_LEN,
    ST_PAY,
    ST_SUM,
    ST_READ,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_cmd_r, ret_cmd_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_fire;

  assign in_ready  = (state_r == ST_SYNC) || (state_r == ST_CMD) || (state_r == ST_LEN) ||
                     (state_r == ST_PAY) || (state_r == ST_SUM);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_fire  = out_valid_r && out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    ret_cmd_nxt   = ret_cmd_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.err_code  = dfm_pkg::EV_DATA;

    unique case (state_r)
      ST_SYNC: begin
        if (in_fire) begin
          if (stat.is_sync) begin
            cmd.open_frame = 1'b1;
            state_nxt      = ST_CMD;
          end else if (!stat.is_idle) begin
            cmd.load_err  = 1'b1;
            cmd.err_code  = dfm_pkg::EV_BAD_SYNC;
            ret_cmd_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_SEND;
          end
        end
      end
      ST_CMD: begin
        if (in_fire) begin
          if (stat.cmd_ok) begin
            cmd.add_byte  = 1'b1;
            cmd.store_cmd = 1'b1;
            state_nxt     = ST_LEN;
          end else begin
            // A bad command that equals sync opens a new frame right away.
            cmd.open_frame = stat.is_sync;
            cmd.load_err   = 1'b1;
            cmd.err_code   = dfm_pkg::EV_BAD_CMD;
            ret_cmd_nxt    = stat.is_sync;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_SEND;
          end
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          if (stat.len_bad) begin
            cmd.load_err  = 1'b1;
            cmd.err_code  = dfm_pkg::EV_BAD_LEN;
            ret_cmd_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_SEND;
          end else begin
            cmd.add_byte  = 1'b1;
            cmd.store_len = 1'b1;
            state_nxt     = stat.len_zero ? ST_SUM : ST_PAY;
          end
        end
      end
      ST_PAY: begin
        if (in_fire) begin
          cmd.add_byte  = 1'b1;
          cmd.store_pay = 1'b1;
          if (stat.pay_done) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (in_fire) begin
          ret_cmd_nxt = 1'b0;
          if (!stat.sum_ok) begin
            cmd.load_err  = 1'b1;
            cmd.err_code  = dfm_pkg::EV_BAD_SUM;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_SEND;
          end else if (stat.frame_empty) begin
            cmd.load_empty = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_SEND;
          end else begin
            cmd.clr_rd = 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Store read and result load for the current payload index.
        cmd.load_data = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_SEND;
      end
      ST_SEND: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (stat.out_last) begin
            state_nxt = ret_cmd_r ? ST_CMD : ST_SYNC;
          end else begin
            cmd.inc_rd = 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      default: begin
        state_nxt     = ST_SYNC;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SYNC;
      ret_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_cmd_r   <= ret_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/sync_len_sum_frame_deframer.sv =====
// Top level of the frame deframer: joins the channels, the controller and
// the datapath. Depends on dfm_pkg, dfm_in_if, dfm_out_if, dfm_ctrl, dfm_dp.
//
// Recovers frames of sync, command (1 to 6), length, payload and an 8-bit
// additive checksum from a byte stream, one byte per word on in_ch. While
// parsing, a byte is taken every cycle. A byte that raises an error holds
// the input until its single event word has been taken on out_ch. After a
// good checksum the payload is read back from the on-chip store, one byte
// per read; store read and result load happen together, each data word is
// held until taken, and the input waits until the whole run has been
// delivered. An empty frame gives one data word with a zero count. The
// store needs no clearing after reset, and the sync byte (cfg_wdata on
// cfg_we, reset 0xA5) may be written at any time the block is idle.
module sync_len_sum_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  dfm_in_if.sink     in_ch,
  dfm_out_if.source  out_ch
);

  dfm_pkg::dfm_cmd_t  cmd;
  dfm_pkg::dfm_stat_t stat;

  dfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dfm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .rx_byte       (in_ch.rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .event_res     (out_ch.event_res),
    .command_code  (out_ch.command_code),
    .payload_count (out_ch.payload_count),
    .payload_value (out_ch.payload_value),
    .byte_position (out_ch.byte_position),
    .last_of_run   (out_ch.last_of_run)
  );

endmodule
